// ----- rtl/lam_pkg.sv -----
`timescale 1ns / 1ps

package lam_pkg;

    // fixed word widths of the ports
    localparam int LAM_IN_W   = 32;
    localparam int LAM_AXIS_W = 18;
    localparam int LAM_OFS_W  = 32;

    // default fraction bits of every fixed-point word
    localparam int LAM_FRAC_BITS = 16;

    // normalizer brings the largest magnitude into [2^(N-1), 2^N)
    localparam int LAM_NORM_BITS = 30;

endpackage

// ----- rtl/lam_norm.sv -----
`timescale 1ns / 1ps

module lam_norm #(
    parameter int W         = 33,
    parameter int FRAC_BITS = lam_pkg::LAM_FRAC_BITS,
    parameter int SW        = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_vec [3],
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output logic signed [FRAC_BITS+1:0] o_axis [3],
    output logic [SW-1:0]           o_side
);
    import lam_pkg::*;

    localparam int NB   = LAM_NORM_BITS;
    localparam int AW   = FRAC_BITS + 2;
    localparam int NCH  = (W + 7) / 8;
    localparam int BLW  = $clog2(W + 1);
    localparam int SQN  = NB + 1;
    localparam int RW   = 2 * NB + 4;
    localparam int DN   = FRAC_BITS + 1;
    localparam int DW   = NB + FRAC_BITS + 2;
    localparam int CW   = 4 + 3 * NB;
    localparam int SQ0  = 6;
    localparam int D0S  = SQ0 + SQN + 1;
    localparam int LAT  = D0S + DN + 1;
    localparam logic signed [AW-1:0] ONE_S = AW'(1) << FRAC_BITS;

    // valid and sideband shift line
    logic          r_v    [1:LAT];
    logic [SW-1:0] r_side [1:LAT];

    // stage 1..3: magnitudes and leading-one search
    logic [W-1:0]  r_s1_m [3];
    logic [2:0]    r_s1_neg;
    logic [W-1:0]  r_s2_m [3];
    logic [2:0]    r_s2_neg;
    logic          r_s2_nz  [NCH];
    logic [2:0]    r_s2_pos [NCH];
    logic [W-1:0]  r_s3_m [3];
    logic [2:0]    r_s3_neg;
    logic [BLW-1:0] r_s3_bl;

    // carried {neg, zero, shifted magnitudes}
    logic [CW-1:0] r_car [4:LAT-1];

    logic [2*NB-1:0] r_s5_sq [3];
    logic [RW-1:0]   r_rem  [SQ0:SQ0+SQN];
    logic [SQN-1:0]  r_root [SQ0:SQ0+SQN];

    logic [DW-1:0]   r_drem [D0S:D0S+DN][3];
    logic [DN-1:0]   r_q    [D0S:D0S+DN][3];
    logic [SQN-1:0]  r_den  [D0S:D0S+DN];

    logic signed [AW-1:0] r_axis [3];

    logic [NCH*8-1:0] n_or;
    logic             n_nz  [NCH];
    logic [2:0]       n_pos [NCH];
    logic [BLW-1:0]   n_bl;
    logic [NB-1:0]    n_sm  [3];
    logic [W+NB-1:0]  n_wide;

    // valid line and sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[1] <= i_side;
        for (int k = 2; k <= LAT; k++) r_side[k] <= r_side[k-1];
    end

    // stage 1: split sign and magnitude
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_m[i]   <= i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
            r_s1_neg[i] <= i_vec[i][W-1];
        end
    end

    // stage 2: per-byte leading one of the ORed magnitudes
    always_comb begin
        n_or = (NCH*8)'(r_s1_m[0] | r_s1_m[1] | r_s1_m[2]);
        for (int c = 0; c < NCH; c++) begin
            n_nz[c]  = |n_or[c*8 +: 8];
            n_pos[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (n_or[c*8+b]) n_pos[c] = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_m   <= r_s1_m;
        r_s2_neg <= r_s1_neg;
        r_s2_nz  <= n_nz;
        r_s2_pos <= n_pos;
    end

    // stage 3: pick the top byte, form the bit length
    always_comb begin
        n_bl = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r_s2_nz[c]) n_bl = BLW'(c * 8) + BLW'(r_s2_pos[c]) + BLW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_m   <= r_s2_m;
        r_s3_neg <= r_s2_neg;
        r_s3_bl  <= n_bl;
    end

    // stage 4: align so the largest magnitude has its top bit at NB-1
    always_comb begin
        n_wide = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_s3_bl > BLW'(NB)) begin
                n_sm[i] = NB'(r_s3_m[i] >> (r_s3_bl - BLW'(NB)));
            end else begin
                n_wide  = (W+NB)'(r_s3_m[i]) << (BLW'(NB) - r_s3_bl);
                n_sm[i] = n_wide[NB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_car[4] <= {r_s3_neg, (r_s3_bl == '0), n_sm[2], n_sm[1], n_sm[0]};
        for (int k = 5; k <= LAT-1; k++) r_car[k] <= r_car[k-1];
    end

    // stage 5: squares, stage 6: sum
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s5_sq[i] <= (2*NB)'(r_car[4][i*NB +: NB]) * (2*NB)'(r_car[4][i*NB +: NB]);
        end
        r_rem[SQ0]  <= RW'(r_s5_sq[0]) + RW'(r_s5_sq[1]) + RW'(r_s5_sq[2]);
        r_root[SQ0] <= '0;
    end

    // square root, one result bit per stage
    for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
        localparam int BI = SQN - k;
        logic [RW-1:0] n_t;
        assign n_t = (RW'(r_root[SQ0+k-1]) << (BI + 1)) + (RW'(1) << (2 * BI));
        always_ff @(posedge i_clk) begin
            if (r_rem[SQ0+k-1] >= n_t) begin
                r_rem[SQ0+k]  <= r_rem[SQ0+k-1] - n_t;
                r_root[SQ0+k] <= r_root[SQ0+k-1] | (SQN'(1) << BI);
            end else begin
                r_rem[SQ0+k]  <= r_rem[SQ0+k-1];
                r_root[SQ0+k] <= r_root[SQ0+k-1];
            end
        end
    end

    // rounded dividend: m * ONE + L/2
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_drem[D0S][i] <= (DW'(r_car[D0S-1][i*NB +: NB]) << FRAC_BITS)
                            + DW'(r_root[SQ0+SQN] >> 1);
            r_q[D0S][i]    <= '0;
        end
        r_den[D0S] <= r_root[SQ0+SQN];
    end

    // restoring division, one quotient bit per stage on three lanes
    for (genvar m = 1; m <= DN; m++) begin : g_div
        localparam int J = DN - m;
        logic [DW-1:0] n_td;
        assign n_td = DW'(r_den[D0S+m-1]) << J;
        always_ff @(posedge i_clk) begin
            r_den[D0S+m] <= r_den[D0S+m-1];
            for (int i = 0; i < 3; i++) begin
                if (r_drem[D0S+m-1][i] >= n_td) begin
                    r_drem[D0S+m][i] <= r_drem[D0S+m-1][i] - n_td;
                    r_q[D0S+m][i]    <= r_q[D0S+m-1][i] | (DN'(1) << J);
                end else begin
                    r_drem[D0S+m][i] <= r_drem[D0S+m-1][i];
                    r_q[D0S+m][i]    <= r_q[D0S+m-1][i];
                end
            end
        end
    end

    // restore signs, force zero vectors to zero
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_car[LAT-1][3*NB]) begin
                r_axis[i] <= '0;
            end else if (r_car[LAT-1][3*NB+1+i]) begin
                r_axis[i] <= -$signed(AW'(r_q[D0S+DN][i]));
            end else begin
                r_axis[i] <= $signed(AW'(r_q[D0S+DN][i]));
            end
        end
    end

    assign o_valid = r_v[LAT];
    assign o_side  = r_side[LAT];
    assign o_axis  = r_axis;

    a_align_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !r_car[4][3*NB]) |->
        ((r_car[4][NB-1] | r_car[4][2*NB-1] | r_car[4][3*NB-1]) == 1'b1))
        else $error("aligned magnitude lost its top bit");

    a_sqrt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[SQ0+SQN] |-> (r_rem[SQ0+SQN] <= (RW'(r_root[SQ0+SQN]) << 1)))
        else $error("square root is not the floor");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_axis[0] <= ONE_S && r_axis[0] >= -ONE_S &&
                     r_axis[1] <= ONE_S && r_axis[1] >= -ONE_S &&
                     r_axis[2] <= ONE_S && r_axis[2] >= -ONE_S))
        else $error("normalized component beyond one");

endmodule

// ----- rtl/look_at_view_matrix.sv -----
`timescale 1ns / 1ps
// Right-handed look-at view matrix, top three rows, signed fixed point.
// Command channel: drive the nine position words and pulse start; a word is
// taken at each rising edge with start high and busy low. busy never rises,
// so a new word may enter in every cycle.
// Result channel: o_strobe marks the single cycle in which the twelve matrix
// fields are valid; capture them at the edge ending that cycle. The receiver
// cannot hold results off, and nothing here needs it to.
// Pipeline: most of its stages lie in the two vector normalizers in series;
// each runs a 31-stage square root and a FRAC_BITS+1 stage divider, one bit
// per stage. Throughput is one word per cycle, with at most one word in
// flight per pipeline stage.
// Reset (i_rst_n low at a rising edge) drops every word in flight; payload
// registers are not cleared, only the valid bits.
// Flow: difference -> normalize (back axis) -> cross product -> normalize
// (right axis) -> cross product with rounding (up axis) -> three dot products
// with the eye, rounded, negated and saturated (row offsets).

module look_at_view_matrix #(
    parameter int FRAC_BITS = lam_pkg::LAM_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_eye_x,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_eye_y,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_eye_z,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_target_x,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_target_y,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_target_z,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_up_x,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_up_y,
    input  logic signed [lam_pkg::LAM_IN_W-1:0]    i_up_z,
    output logic                                   o_strobe,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_right_x,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_right_y,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_right_z,
    output logic signed [lam_pkg::LAM_OFS_W-1:0]   o_right_offset,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_upaxis_x,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_upaxis_y,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_upaxis_z,
    output logic signed [lam_pkg::LAM_OFS_W-1:0]   o_upaxis_offset,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_back_x,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_back_y,
    output logic signed [lam_pkg::LAM_AXIS_W-1:0]  o_back_z,
    output logic signed [lam_pkg::LAM_OFS_W-1:0]   o_back_offset
);
    import lam_pkg::*;

    localparam int IW  = LAM_IN_W;
    localparam int AW  = FRAC_BITS + 2;            // axis component, holds +-ONE
    localparam int DW  = IW + 1;                    // eye - target
    localparam int PW  = IW + AW;                   // up * z
    localparam int XW  = PW + 1;                    // raw right axis
    localparam int YP  = 2 * AW;                    // z * x
    localparam int YM  = YP + 2;                    // rounded up-axis magnitude
    localparam int OP  = AW + IW;                   // axis * eye
    localparam int OD  = OP + 2;                    // dot product
    localparam int OM  = OD + 1;                    // rounded offset magnitude
    localparam int S1W = 6 * IW;
    localparam int S2W = 3 * AW + 3 * IW;

    localparam logic [YM-1:0] Y_HALF = YM'(1) << (FRAC_BITS - 1);
    localparam logic [YM-1:0] Y_ONE  = YM'(1) << FRAC_BITS;
    localparam logic [OM-1:0] O_HALF = OM'(1) << (FRAC_BITS - 1);
    localparam logic [OM-1:0] O_POS  = (OM'(1) << (LAM_OFS_W - 1)) - OM'(1);
    localparam logic [OM-1:0] O_NEG  = OM'(1) << (LAM_OFS_W - 1);
    localparam logic signed [AW-1:0] ONE_S = AW'(1) << FRAC_BITS;

    logic n_acc;

    // input and difference stages
    logic                 r0_v, r1_v;
    logic signed [IW-1:0] r0_eye [3], r0_tgt [3], r0_up [3];
    logic signed [IW-1:0] r1_eye [3], r1_up [3];
    logic signed [DW-1:0] r1_d [3];
    logic [S1W-1:0]       n1_side_in;

    // back-axis normalizer
    logic                 n1_v;
    logic signed [AW-1:0] n1_z [3];
    logic [S1W-1:0]       n1_side;
    logic signed [IW-1:0] n1_eye [3], n1_up [3];

    // right-axis cross product
    logic                 r_c1_v, r_c2_v;
    logic signed [PW-1:0] r_c1_p [6];
    logic signed [AW-1:0] r_c1_z [3], r_c2_z [3];
    logic signed [IW-1:0] r_c1_eye [3], r_c2_eye [3];
    logic signed [XW-1:0] r_c2_xr [3];
    logic [S2W-1:0]       n2_side_in;

    // right-axis normalizer
    logic                 n2_v;
    logic signed [AW-1:0] n2_x [3];
    logic [S2W-1:0]       n2_side;
    logic signed [AW-1:0] n2_z [3];
    logic signed [IW-1:0] n2_eye [3];

    // up axis
    logic                   r_y1_v, r_y2_v, r_y3_v, r_y4_v;
    logic signed [YP-1:0]   r_y1_p [6];
    logic signed [YP:0]     r_y2_d [3];
    logic [YP:0]            r_y3_m [3];
    logic [2:0]             r_y3_neg;
    logic signed [AW-1:0]   r_y4_y [3];
    logic signed [AW-1:0]   r_y1_x [3], r_y2_x [3], r_y3_x [3], r_y4_x [3];
    logic signed [AW-1:0]   r_y1_z [3], r_y2_z [3], r_y3_z [3], r_y4_z [3];
    logic signed [IW-1:0]   r_y1_eye [3], r_y2_eye [3], r_y3_eye [3], r_y4_eye [3];
    logic [YM-1:0]          n_yr [3];
    logic signed [AW-1:0]   n_ymag [3];

    // row offsets
    logic                   r_o1_v, r_o2_v, r_o3_v, r_o4_v;
    logic signed [AW-1:0]   n_rows [3][3];
    logic signed [OP-1:0]   r_o1_p [3][3];
    logic signed [OD-1:0]   r_o2_dot [3];
    logic [OD-1:0]          r_o3_m [3];
    logic [2:0]             r_o3_neg;
    logic signed [AW-1:0]   r_o1_ax [3][3], r_o2_ax [3][3], r_o3_ax [3][3], r_o4_ax [3][3];
    logic signed [LAM_OFS_W-1:0] r_o4_ofs [3];
    logic [OM-1:0]          n_om [3];
    logic [OM-1:0]          n_omn [3];

    // never stall: the pipeline takes a word every cycle
    assign busy  = 1'b0;
    assign n_acc = start && !busy;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v   <= 1'b0;
            r1_v   <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_y1_v <= 1'b0;
            r_y2_v <= 1'b0;
            r_y3_v <= 1'b0;
            r_y4_v <= 1'b0;
            r_o1_v <= 1'b0;
            r_o2_v <= 1'b0;
            r_o3_v <= 1'b0;
            r_o4_v <= 1'b0;
        end else begin
            r0_v   <= n_acc;
            r1_v   <= r0_v;
            r_c1_v <= n1_v;
            r_c2_v <= r_c1_v;
            r_y1_v <= n2_v;
            r_y2_v <= r_y1_v;
            r_y3_v <= r_y2_v;
            r_y4_v <= r_y3_v;
            r_o1_v <= r_y4_v;
            r_o2_v <= r_o1_v;
            r_o3_v <= r_o2_v;
            r_o4_v <= r_o3_v;
        end
    end

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (n_acc) begin
            r0_eye <= '{i_eye_x, i_eye_y, i_eye_z};
            r0_tgt <= '{i_target_x, i_target_y, i_target_z};
            r0_up  <= '{i_up_x, i_up_y, i_up_z};
        end
    end

    // eye - target at full width
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= DW'(r0_eye[i]) - DW'(r0_tgt[i]);
        end
        r1_eye <= r0_eye;
        r1_up  <= r0_up;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_side_in[i*IW +: IW]      = r1_eye[i];
            n1_side_in[(3+i)*IW +: IW]  = r1_up[i];
            n1_eye[i] = $signed(n1_side[i*IW +: IW]);
            n1_up[i]  = $signed(n1_side[(3+i)*IW +: IW]);
        end
    end

    lam_norm #(
        .W         (DW),
        .FRAC_BITS (FRAC_BITS),
        .SW        (S1W)
    ) u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_vec   (r1_d),
        .i_side  (n1_side_in),
        .o_valid (n1_v),
        .o_axis  (n1_z),
        .o_side  (n1_side)
    );

    // up x z: products, then differences
    always_ff @(posedge i_clk) begin
        r_c1_p[0] <= PW'(n1_up[1]) * PW'(n1_z[2]);
        r_c1_p[1] <= PW'(n1_up[2]) * PW'(n1_z[1]);
        r_c1_p[2] <= PW'(n1_up[2]) * PW'(n1_z[0]);
        r_c1_p[3] <= PW'(n1_up[0]) * PW'(n1_z[2]);
        r_c1_p[4] <= PW'(n1_up[0]) * PW'(n1_z[1]);
        r_c1_p[5] <= PW'(n1_up[1]) * PW'(n1_z[0]);
        r_c1_z    <= n1_z;
        r_c1_eye  <= n1_eye;
        for (int i = 0; i < 3; i++) begin
            r_c2_xr[i] <= XW'(r_c1_p[2*i]) - XW'(r_c1_p[2*i+1]);
        end
        r_c2_z   <= r_c1_z;
        r_c2_eye <= r_c1_eye;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_side_in[i*AW +: AW]            = r_c2_z[i];
            n2_side_in[3*AW + i*IW +: IW]     = r_c2_eye[i];
            n2_z[i]   = $signed(n2_side[i*AW +: AW]);
            n2_eye[i] = $signed(n2_side[3*AW + i*IW +: IW]);
        end
    end

    lam_norm #(
        .W         (XW),
        .FRAC_BITS (FRAC_BITS),
        .SW        (S2W)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c2_v),
        .i_vec   (r_c2_xr),
        .i_side  (n2_side_in),
        .o_valid (n2_v),
        .o_axis  (n2_x),
        .o_side  (n2_side)
    );

    // up axis = z x x, rounded half away from zero, clamped to +-ONE
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_yr[i] = (YM'(r_y3_m[i]) + Y_HALF) >> FRAC_BITS;
            if (n_yr[i] > Y_ONE) n_yr[i] = Y_ONE;
            n_ymag[i] = $signed(AW'(n_yr[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_y1_p[0] <= YP'(n2_z[1]) * YP'(n2_x[2]);
        r_y1_p[1] <= YP'(n2_z[2]) * YP'(n2_x[1]);
        r_y1_p[2] <= YP'(n2_z[2]) * YP'(n2_x[0]);
        r_y1_p[3] <= YP'(n2_z[0]) * YP'(n2_x[2]);
        r_y1_p[4] <= YP'(n2_z[0]) * YP'(n2_x[1]);
        r_y1_p[5] <= YP'(n2_z[1]) * YP'(n2_x[0]);
        for (int i = 0; i < 3; i++) begin
            r_y2_d[i]   <= (YP+1)'(r_y1_p[2*i]) - (YP+1)'(r_y1_p[2*i+1]);
            r_y3_neg[i] <= r_y2_d[i][YP];
            r_y3_m[i]   <= r_y2_d[i][YP] ? (YP+1)'(-r_y2_d[i]) : (YP+1)'(r_y2_d[i]);
            r_y4_y[i]   <= r_y3_neg[i] ? -n_ymag[i] : n_ymag[i];
        end
        r_y1_x <= n2_x;  r_y2_x <= r_y1_x;  r_y3_x <= r_y2_x;  r_y4_x <= r_y3_x;
        r_y1_z <= n2_z;  r_y2_z <= r_y1_z;  r_y3_z <= r_y2_z;  r_y4_z <= r_y3_z;
        r_y1_eye <= n2_eye;
        r_y2_eye <= r_y1_eye;
        r_y3_eye <= r_y2_eye;
        r_y4_eye <= r_y3_eye;
    end

    // offsets: -(axis . eye), rounded, saturated
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rows[0][i] = r_y4_x[i];
            n_rows[1][i] = r_y4_y[i];
            n_rows[2][i] = r_y4_z[i];
            n_om[i]  = (OM'(r_o3_m[i]) + O_HALF) >> FRAC_BITS;
            n_omn[i] = -n_om[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                r_o1_p[r][i] <= OP'(n_rows[r][i]) * OP'(r_y4_eye[i]);
            end
            r_o2_dot[r] <= OD'(r_o1_p[r][0]) + OD'(r_o1_p[r][1]) + OD'(r_o1_p[r][2]);
            r_o3_neg[r] <= r_o2_dot[r][OD-1];
            r_o3_m[r]   <= r_o2_dot[r][OD-1] ? OD'(-r_o2_dot[r]) : OD'(r_o2_dot[r]);
            // negative dot gives a positive offset, and the other way round
            if (r_o3_neg[r]) begin
                r_o4_ofs[r] <= (n_om[r] > O_POS) ? $signed(LAM_OFS_W'(O_POS))
                                                 : $signed(n_om[r][LAM_OFS_W-1:0]);
            end else begin
                r_o4_ofs[r] <= (n_om[r] > O_NEG) ? $signed(LAM_OFS_W'(O_NEG))
                                                 : $signed(n_omn[r][LAM_OFS_W-1:0]);
            end
        end
        r_o1_ax <= n_rows;
        r_o2_ax <= r_o1_ax;
        r_o3_ax <= r_o2_ax;
        r_o4_ax <= r_o3_ax;
    end

    assign o_strobe        = r_o4_v;
    assign o_right_x       = LAM_AXIS_W'(r_o4_ax[0][0]);
    assign o_right_y       = LAM_AXIS_W'(r_o4_ax[0][1]);
    assign o_right_z       = LAM_AXIS_W'(r_o4_ax[0][2]);
    assign o_right_offset  = r_o4_ofs[0];
    assign o_upaxis_x      = LAM_AXIS_W'(r_o4_ax[1][0]);
    assign o_upaxis_y      = LAM_AXIS_W'(r_o4_ax[1][1]);
    assign o_upaxis_z      = LAM_AXIS_W'(r_o4_ax[1][2]);
    assign o_upaxis_offset = r_o4_ofs[1];
    assign o_back_x        = LAM_AXIS_W'(r_o4_ax[2][0]);
    assign o_back_y        = LAM_AXIS_W'(r_o4_ax[2][1]);
    assign o_back_z        = LAM_AXIS_W'(r_o4_ax[2][2]);
    assign o_back_offset   = r_o4_ofs[2];

    // a zero back axis leaves nothing to build the other rows from
    a_zero_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o4_v && r_o4_ax[2][0] == '0 && r_o4_ax[2][1] == '0 && r_o4_ax[2][2] == '0) |->
        (r_o4_ax[0][0] == '0 && r_o4_ax[0][1] == '0 && r_o4_ax[0][2] == '0 &&
         r_o4_ofs[2] == '0))
        else $error("zero back axis with nonzero right axis or offset");

    // a zero right axis forces a zero up axis
    a_zero_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o4_v && r_o4_ax[0][0] == '0 && r_o4_ax[0][1] == '0 && r_o4_ax[0][2] == '0) |->
        (r_o4_ax[1][0] == '0 && r_o4_ax[1][1] == '0 && r_o4_ax[1][2] == '0))
        else $error("zero right axis with nonzero up axis");

    a_up_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_y4_v |-> (r_y4_y[0] <= ONE_S && r_y4_y[0] >= -ONE_S &&
                    r_y4_y[1] <= ONE_S && r_y4_y[1] >= -ONE_S &&
                    r_y4_y[2] <= ONE_S && r_y4_y[2] >= -ONE_S))
        else $error("up axis component beyond one");

endmodule

// ----- test/look_at_view_matrix_tb.sv -----
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

    import lam_pkg::*;

    localparam int FB      = LAM_FRAC_BITS;
    localparam int LATENCY = 2 * FB + 92;
    localparam int N_RAND  = 700;

    typedef logic signed [LAM_IN_W-1:0]   in_word_t;
    typedef logic signed [LAM_AXIS_W-1:0] axis_t;
    typedef logic signed [LAM_OFS_W-1:0]  ofs_t;

    // one camera word: eye, target and up, index 0..2 = x..z
    typedef struct {
        in_word_t eye[3];
        in_word_t tgt[3];
        in_word_t up[3];
    } camera_t;

    // matrix rows: 0 right, 1 up axis, 2 back
    typedef struct {
        axis_t ax[3][3];
        ofs_t  ofs[3];
    } view_rows_t;

    // Expected-matrix store with its own fixed-point view predictor.
    class view_scoreboard;
        view_rows_t pending[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("%0t ns MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        static function longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // scale the largest magnitude into [2^29, 2^30), then divide by the length
        static function void unit_vec(input longint v[3], output longint o[3]);
            longint unsigned m[3];
            longint unsigned big, sum, len, q;
            int bits;
            big = 0;
            sum = 0;
            bits = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (v[i] < 0) ? -v[i] : v[i];
                if (m[i] > big) big = m[i];
            end
            if (big == 0) begin
                for (int i = 0; i < 3; i++) o[i] = 0;
                return;
            end
            while (bits < 64 && (big >> bits) != 0) bits++;
            for (int i = 0; i < 3; i++) begin
                if (bits > LAM_NORM_BITS) m[i] >>= (bits - LAM_NORM_BITS);
                else                      m[i] <<= (LAM_NORM_BITS - bits);
                sum += m[i] * m[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (m[i] * (64'd1 << FB) + (len >> 1)) / len;
                o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        // drop fraction bits, round half away from zero
        static function longint round_down(input longint v);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << (FB - 1))) >> FB;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        static function longint clip(input longint v, input longint lo, input longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note(input camera_t c);
            longint e[3], d[3], z[3], xr[3], x[3], y[3], dot;
            longint rows[3][3];
            view_rows_t r;
            for (int i = 0; i < 3; i++) begin
                e[i] = c.eye[i];
                d[i] = longint'(c.eye[i]) - longint'(c.tgt[i]);
            end
            unit_vec(d, z);
            xr[0] = c.up[1] * z[2] - c.up[2] * z[1];
            xr[1] = c.up[2] * z[0] - c.up[0] * z[2];
            xr[2] = c.up[0] * z[1] - c.up[1] * z[0];
            unit_vec(xr, x);
            y[0] = clip(round_down(z[1] * x[2] - z[2] * x[1]), -(64'd1 << FB), 64'd1 << FB);
            y[1] = clip(round_down(z[2] * x[0] - z[0] * x[2]), -(64'd1 << FB), 64'd1 << FB);
            y[2] = clip(round_down(z[0] * x[1] - z[1] * x[0]), -(64'd1 << FB), 64'd1 << FB);
            rows[0] = x;
            rows[1] = y;
            rows[2] = z;
            for (int k = 0; k < 3; k++) begin
                dot = rows[k][0] * e[0] + rows[k][1] * e[1] + rows[k][2] * e[2];
                for (int i = 0; i < 3; i++) r.ax[k][i] = axis_t'(rows[k][i]);
                r.ofs[k] = ofs_t'(clip(-round_down(dot), -(64'd1 << 31), (64'd1 << 31) - 1));
            end
            pending.push_back(r);
        endfunction

        task check(input view_rows_t got);
            view_rows_t want;
            if (pending.size() == 0) begin
                report("matrix strobed with nothing outstanding");
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++)
                    if (got.ax[k][i] !== want.ax[k][i])
                        report($sformatf("row %0d col %0d: got %0d want %0d",
                                         k, i, got.ax[k][i], want.ax[k][i]));
                if (got.ofs[k] !== want.ofs[k])
                    report($sformatf("row %0d offset: got %0d want %0d",
                                     k, got.ofs[k], want.ofs[k]));
            end
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    in_word_t i_eye_x, i_eye_y, i_eye_z;
    in_word_t i_target_x, i_target_y, i_target_z;
    in_word_t i_up_x, i_up_y, i_up_z;
    logic     o_strobe;
    axis_t    o_right_x, o_right_y, o_right_z;
    ofs_t     o_right_offset;
    axis_t    o_upaxis_x, o_upaxis_y, o_upaxis_z;
    ofs_t     o_upaxis_offset;
    axis_t    o_back_x, o_back_y, o_back_z;
    ofs_t     o_back_offset;

    view_scoreboard sb;

    look_at_view_matrix #(.FRAC_BITS(FB)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_eye_x         (i_eye_x),
        .i_eye_y         (i_eye_y),
        .i_eye_z         (i_eye_z),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .i_target_z      (i_target_z),
        .i_up_x          (i_up_x),
        .i_up_y          (i_up_y),
        .i_up_z          (i_up_z),
        .o_strobe        (o_strobe),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_right_z       (o_right_z),
        .o_right_offset  (o_right_offset),
        .o_upaxis_x      (o_upaxis_x),
        .o_upaxis_y      (o_upaxis_y),
        .o_upaxis_z      (o_upaxis_z),
        .o_upaxis_offset (o_upaxis_offset),
        .o_back_x        (o_back_x),
        .o_back_y        (o_back_y),
        .o_back_z        (o_back_z),
        .o_back_offset   (o_back_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond 715 words with the longest random gaps plus the pipeline depth.
    initial begin
        #5_000_000;
        $display("** look_at_view_matrix: FAILED **");
        $finish;
    end

    // Capture every strobed matrix; the receiver has no way to stall.
    always @(posedge i_clk) begin
        view_rows_t got;
        if (i_rst_n && o_strobe) begin
            got.ax[0] = '{o_right_x, o_right_y, o_right_z};
            got.ax[1] = '{o_upaxis_x, o_upaxis_y, o_upaxis_z};
            got.ax[2] = '{o_back_x, o_back_y, o_back_z};
            got.ofs   = '{o_right_offset, o_upaxis_offset, o_back_offset};
            sb.check(got);
        end
    end

    function automatic camera_t make_cam(input in_word_t ex, ey, ez, tx, ty, tz, ux, uy, uz);
        camera_t c;
        c.eye = '{ex, ey, ez};
        c.tgt = '{tx, ty, tz};
        c.up  = '{ux, uy, uz};
        return c;
    endfunction

    // Draw one word: full range, small scene coordinates, or an edge value.
    function automatic in_word_t rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return in_word_t'($urandom);
            2, 3: return in_word_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            4:    return in_word_t'($signed($urandom_range(0, 2048)) - 1024);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0001_0000;
                    default: return 32'sh0;
                endcase
            end
        endcase
    endfunction

    // Random camera; sometimes force the eye onto the target or up along the view.
    function automatic camera_t rand_cam();
        camera_t c;
        int shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_coord();
            c.tgt[i] = rand_coord();
            c.up[i]  = rand_coord();
        end
        if (shape == 0) begin
            c.tgt = c.eye;
        end else if (shape == 1) begin
            // up along eye - target when the difference fits a word
            for (int i = 0; i < 3; i++) begin
                c.tgt[i] = c.eye[i] - in_word_t'($signed($urandom_range(0, 2000)) - 1000);
                c.up[i]  = c.eye[i] - c.tgt[i];
            end
        end else if (shape == 2) begin
            c.up = '{0, 0, 0};
        end else if (shape == 3) begin
            // target a hair away from the eye: tiny back vector
            for (int i = 0; i < 3; i++)
                c.tgt[i] = c.eye[i] + in_word_t'($signed($urandom_range(0, 2)) - 1);
        end
        return c;
    endfunction

    // Hold start across back-to-back words; lower it only for a real gap.
    task send_cam(input camera_t c, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_eye_x    <= c.eye[0];
        i_eye_y    <= c.eye[1];
        i_eye_z    <= c.eye[2];
        i_target_x <= c.tgt[0];
        i_target_y <= c.tgt[1];
        i_target_z <= c.tgt[2];
        i_up_x     <= c.up[0];
        i_up_y     <= c.up[1];
        i_up_z     <= c.up[2];
        start      <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note(c);
    endtask

    initial begin
        camera_t directed[$];
        int gap, waited;
        bit burst;
        sb = new();
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_eye_x    = '0;
        i_eye_y    = '0;
        i_eye_z    = '0;
        i_target_x = '0;
        i_target_y = '0;
        i_target_z = '0;
        i_up_x     = '0;
        i_up_y     = '0;
        i_up_z     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero, and eye on target: whole matrix collapses to zero
        directed.push_back(make_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cam(32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
                                    32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
                                    0, 32'sh0001_0000, 0));
        // ordinary camera at +z looking at the origin, y up
        directed.push_back(make_cam(0, 0, 32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0));
        directed.push_back(make_cam(32'sh0004_0000, 32'sh0003_0000, 32'sh0002_0000,
                                    -32'sh0001_0000, 32'sh0000_8000, 0,
                                    0, 32'sh0001_0000, 0));
        // up zero, and up parallel to the view axis: right and up rows zero
        directed.push_back(make_cam(0, 0, 32'sh0005_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cam(0, 0, 32'sh0005_0000, 0, 0, 0, 0, 0, 32'sh0001_0000));
        directed.push_back(make_cam(0, 0, 32'sh0005_0000, 0, 0, 0, 0, 0, -32'sh7fff_ffff));
        // extremes of every field, difference wider than a word
        directed.push_back(make_cam(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
        directed.push_back(make_cam(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                    32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
        directed.push_back(make_cam(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0,
                                    0, 32'sh7fff_ffff, 0));
        // offsets saturating high and low
        directed.push_back(make_cam(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                    32'sh7fff_fffe, 32'sh7fff_fffe, 32'sh7fff_fffe,
                                    0, 32'sh0001_0000, 32'sh0000_0100));
        directed.push_back(make_cam(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh8000_0001, 32'sh8000_0001, 32'sh8000_0001,
                                    32'sh0000_0100, 32'sh0001_0000, 0));
        // one-ulp differences and all-ones bit patterns
        directed.push_back(make_cam(1, 0, 0, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_cam(-1, -1, -1, 0, 0, 0, -1, 1, -1));
        directed.push_back(make_cam(32'sh5555_5555, 32'sh2aaa_aaaa, -32'sh5555_5555,
                                    32'sh1234_5678, -32'sh0fed_cba9, 32'sh0000_ffff,
                                    32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        foreach (directed[i]) send_cam(directed[i], 0);

        // random: bursts without gaps alternate with stretches of random gaps
        burst = 1'b0;
        for (int n = 0; n < N_RAND; n++) begin
            if ($urandom_range(0, 39) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 5);
            send_cam(rand_cam(), gap);
        end
        start <= 1'b0;

        // drain the pipeline, then give stray strobes a chance to show up
        waited = 0;
        while (sb.pending.size() != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d matrices never strobed", sb.pending.size()));

        if (sb.errors == 0) begin
            $display("** look_at_view_matrix: PASSED **");
        end else begin
            $display("** look_at_view_matrix: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lam_pkg.sv
rtl/lam_norm.sv
rtl/look_at_view_matrix.sv
test/look_at_view_matrix_tb.sv
